### src/q4br_pkg.sv
// ----------------------------------------------------------------------------
// q4br_pkg
// Shared types, constants and the half-precision bias function for the
// block repacker.
// ----------------------------------------------------------------------------
package q4br_pkg;

  localparam int unsigned BlockBytes = 18;
  localparam int unsigned PosW       = 5;
  localparam int unsigned QDepth     = 2;

  // one finished block: scale and the four element words
  typedef struct packed {
    logic [15:0] scale;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
  } blk_t;

  // Compute -8 * h in half precision (exact, overflowing to infinity, or NaN for a NaN input).
  function automatic logic [15:0] neg_eight(input logic [15:0] h);
    logic        sgn;
    logic [4:0]  e;
    logic [9:0]  f;
    logic [12:0] m8;
    logic [15:0] r;
    sgn = ~h[15];
    e   = h[14:10];
    f   = h[9:0];
    m8  = {f, 3'b000};
    r   = '0;
    if (e == 5'h1f) begin
      r = (f != 10'd0) ? {sgn, 5'h1f, 10'h200} : {sgn, 5'h1f, 10'h000};
    end else if (e == 5'd0) begin
      // subnormal: scale up and renormalize at most three steps
      if (m8 < 13'h400) begin
        r = {sgn, 5'd0, m8[9:0]};
      end else if (m8[12]) begin
        r = {sgn, 5'd3, m8[11:2]};
      end else if (m8[11]) begin
        r = {sgn, 5'd2, m8[10:1]};
      end else begin
        r = {sgn, 5'd1, m8[9:0]};
      end
    end else if ({1'b0, e} + 6'd3 >= 6'd31) begin
      r = {sgn, 5'h1f, 10'h000};
    end else begin
      r = {sgn, e + 5'd3, f};
    end
    return r;
  endfunction

endpackage

### src/q4_block_repack.sv
// ----------------------------------------------------------------------------
// q4_block_repack
// Repack 18-byte 4-bit quantized blocks into scale, bias and four nibble words.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while valid and not stalled; every 18th byte completes a block,
// which enters a two-entry queue and is offered from the next cycle on. The
// result carries the scale, -8 * scale in half precision and the elements
// repacked eight nibbles to a word. Input stalls only when both queue entries
// hold blocks not yet taken by the output side.
module q4_block_repack (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] scale_half_o,
  output logic [15:0] bias_half_o,
  output logic [31:0] packed_word0_o,
  output logic [31:0] packed_word1_o,
  output logic [31:0] packed_word2_o,
  output logic [31:0] packed_word3_o
);

  logic           push;
  logic           full;
  q4br_pkg::blk_t blk;

  q4br_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .data_byte_i,
    .push_o(push), .push_blk_o(blk), .full_i(full)
  );

  q4br_back u_back (
    .clk_i, .rst_ni, .push_i(push), .push_blk_i(blk), .full_o(full),
    .out_valid, .out_stall, .scale_half_o, .bias_half_o,
    .packed_word0_o, .packed_word1_o, .packed_word2_o, .packed_word3_o
  );

endmodule

### src/q4br_front.sv
// ----------------------------------------------------------------------------
// q4br_front
// Track the byte position, assemble scale and nibble words, and push one
// finished block per 18 bytes.
// ----------------------------------------------------------------------------
module q4br_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           data_byte_i,
  output logic                 push_o,
  output q4br_pkg::blk_t       push_blk_o,
  input  logic                 full_i
);

  logic [q4br_pkg::PosW-1:0] pos_q, pos_d;
  logic [15:0]  scale_q;
  logic [31:0]  w_q [4];
  logic         acc;
  logic         last;
  logic [3:0]   j;
  logic [15:0]  scale_n;
  logic [31:0]  w_n [4];

  assign in_stall = full_i;
  assign acc  = in_valid && !full_i;
  assign last = (pos_q == q4br_pkg::PosW'(q4br_pkg::BlockBytes - 1));
  assign j    = 4'(pos_q - q4br_pkg::PosW'(2));

  // merge the current byte into scale and nibble words
  always_comb begin
    scale_n = scale_q;
    for (int k = 0; k < 4; k++) w_n[k] = w_q[k];
    if (pos_q == '0) begin
      scale_n[7:0] = data_byte_i;
    end else if (pos_q == q4br_pkg::PosW'(1)) begin
      scale_n[15:8] = data_byte_i;
    end else begin
      w_n[{1'b0, j[3]}][{j[2:0], 2'b00} +: 4] = data_byte_i[3:0];
      w_n[{1'b1, j[3]}][{j[2:0], 2'b00} +: 4] = data_byte_i[7:4];
    end
  end

  // advance the position, wrap at the block end
  always_comb begin
    pos_d = pos_q;
    if (acc) pos_d = last ? '0 : pos_q + q4br_pkg::PosW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      scale_q <= scale_n;
      for (int k = 0; k < 4; k++) w_q[k] <= w_n[k];
    end
  end

  assign push_o     = acc && last;
  assign push_blk_o = '{scale: scale_n, w0: w_n[0], w1: w_n[1], w2: w_n[2], w3: w_n[3]};

`ifndef NO_ASSERTIONS
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < q4br_pkg::PosW'(q4br_pkg::BlockBytes))
    else $error("position out of range");
  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> pos_q == '0)
    else $error("position did not wrap after block");
  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i)
    else $error("push into full queue");
`endif

endmodule

### src/q4br_back.sv
// ----------------------------------------------------------------------------
// q4br_back
// Two-entry queue of finished blocks; compute the bias on the way out.
// ----------------------------------------------------------------------------
module q4br_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  q4br_pkg::blk_t       push_blk_i,
  output logic                 full_o,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          scale_half_o,
  output logic [15:0]          bias_half_o,
  output logic [31:0]          packed_word0_o,
  output logic [31:0]          packed_word1_o,
  output logic [31:0]          packed_word2_o,
  output logic [31:0]          packed_word3_o
);

  q4br_pkg::blk_t mem_q [q4br_pkg::QDepth];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q, cnt_d;
  logic           pop;
  q4br_pkg::blk_t head;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (cnt_q != 2'd0);
  assign full_o    = (cnt_q == 2'(q4br_pkg::QDepth));
  assign head      = mem_q[rp_q];

  // hold the count, step on push and pop
  always_comb begin
    cnt_d = cnt_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wp_q <= ~wp_q;
      if (pop)    rp_q <= ~rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_blk_i;
  end

  assign scale_half_o   = head.scale;
  assign bias_half_o    = q4br_pkg::neg_eight(head.scale);
  assign packed_word0_o = head.w0;
  assign packed_word1_o = head.w1;
  assign packed_word2_o = head.w2;
  assign packed_word3_o = head.w3;

`ifndef NO_ASSERTIONS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(q4br_pkg::QDepth))
    else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push while full");
  a_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> wp_q == rp_q)
    else $error("pointers disagree with count");
`endif

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drive random and directed 18-byte quantized blocks into q4_block_repack and
// check each repacked word (scale, bias, four nibble words) against a
// built-in prediction of the block, under random idling on both sides.
// ----------------------------------------------------------------------------
class repack_scoreboard;
  typedef struct {
    logic [15:0] scale;
    logic [15:0] bias;
    logic [31:0] w [4];
  } block_word_t;

  int unsigned   byte_pos;
  logic [15:0]   scale_acc;
  logic [31:0]   nib_acc [4];
  block_word_t   pending_blocks [$];
  int unsigned   errors;

  function new();
    byte_pos = 0;
    scale_acc = '0;
    foreach (nib_acc[i]) nib_acc[i] = '0;
    errors = 0;
  endfunction

  // -8 * h in half precision: exact, a signed infinity on overflow, or NaN for a NaN input
  function logic [15:0] half_times_neg8(logic [15:0] h);
    logic       sgn;
    logic [4:0] ex;
    logic [9:0] fr;
    int unsigned mant;
    int unsigned nexp;
    sgn = ~h[15];
    ex = h[14:10];
    fr = h[9:0];
    if (ex == 5'h1f) return (fr != 0) ? {sgn, 15'h7e00} : {sgn, 15'h7c00};
    if (ex == 0) begin
      mant = fr * 8;
      nexp = 1;
      if (mant < 'h400) return {sgn, 5'd0, mant[9:0]};
      while (mant >= 'h800) begin
        mant = mant >> 1;
        nexp++;
      end
      return {sgn, nexp[4:0], mant[9:0]};
    end
    if (ex >= 28) return {sgn, 15'h7c00};
    return {sgn, ex + 5'd3, fr};
  endfunction

  // note one accepted byte; queue a finished block
  function void note_byte(logic [7:0] b);
    int unsigned j;
    block_word_t blk;
    if (byte_pos == 0) scale_acc[7:0] = b;
    else if (byte_pos == 1) scale_acc[15:8] = b;
    else begin
      j = byte_pos - 2;
      nib_acc[j / 8][(j % 8) * 4 +: 4] = b[3:0];
      nib_acc[j / 8 + 2][(j % 8) * 4 +: 4] = b[7:4];
    end
    if (byte_pos == 17) begin
      blk.scale = scale_acc;
      blk.bias = half_times_neg8(scale_acc);
      foreach (nib_acc[i]) blk.w[i] = nib_acc[i];
      pending_blocks.push_back(blk);
      byte_pos = 0;
    end else begin
      byte_pos++;
    end
  endfunction

  function void check_block(logic [15:0] sc, logic [15:0] bi, logic [31:0] w0,
                            logic [31:0] w1, logic [31:0] w2, logic [31:0] w3);
    block_word_t e;
    if (pending_blocks.size() == 0) begin
      $error("unexpected result word, scale %h", sc);
      errors++;
      return;
    end
    e = pending_blocks.pop_front();
    if (sc !== e.scale) begin
      $error("scale_half: expected %h actual %h", e.scale, sc); errors++;
    end
    if (bi !== e.bias) begin
      $error("bias_half: expected %h actual %h", e.bias, bi); errors++;
    end
    if (w0 !== e.w[0]) begin
      $error("packed_word0: expected %h actual %h", e.w[0], w0); errors++;
    end
    if (w1 !== e.w[1]) begin
      $error("packed_word1: expected %h actual %h", e.w[1], w1); errors++;
    end
    if (w2 !== e.w[2]) begin
      $error("packed_word2: expected %h actual %h", e.w[2], w2); errors++;
    end
    if (w3 !== e.w[3]) begin
      $error("packed_word3: expected %h actual %h", e.w[3], w3); errors++;
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte_i;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] scale_half_o;
  logic [15:0] bias_half_o;
  logic [31:0] packed_word0_o;
  logic [31:0] packed_word1_o;
  logic [31:0] packed_word2_o;
  logic [31:0] packed_word3_o;

  repack_scoreboard sb;
  int unsigned cycle_count;
  bit          no_idle;
  bit          hold_off;

  q4_block_repack dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // count cycles and give up at the limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("q4_block_repack test failed");
      $finish;
    end
  end

  // check each accepted result word
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall)
      sb.check_block(scale_half_o, bias_half_o, packed_word0_o, packed_word1_o,
                     packed_word2_o, packed_word3_o);
  end

  // receiver: random stall, or a long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_off) out_stall <= 1'b1;
    else if (no_idle) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 27);
  end

  // offer one byte, with a random gap first, and wait until it is taken;
  // valid stays up afterward until the next byte or gap replaces it
  task automatic send_byte(logic [7:0] b);
    while (!no_idle && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sb.note_byte(b);
    @(negedge clk_i);
  endtask

  task automatic send_block(logic [15:0] scale, bit rand_data, logic [7:0] fill);
    send_byte(scale[7:0]);
    send_byte(scale[15:8]);
    for (int i = 0; i < 16; i++) send_byte(rand_data ? 8'($urandom) : fill);
  endtask

  // random scale leaning on exponent extremes
  function automatic logic [15:0] pick_scale();
    logic [15:0] s;
    s = 16'($urandom);
    case ($urandom_range(5))
      0: s[14:10] = 5'd0;
      1: s[14:10] = 5'h1f;
      2: s[14:10] = 5'($urandom_range(26, 29));
      default: ;
    endcase
    return s;
  endfunction

  initial begin
    logic [15:0] directed [12];
    sb = new();
    no_idle = 1'b0;
    hold_off = 1'b0;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    data_byte_i = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // zero, infinities, NaN, subnormals, overflow boundary, ordinary
    directed = '{16'h0000, 16'h8000, 16'h7c00, 16'hfc00, 16'h7d23, 16'h0001,
                 16'h83ff, 16'h0080, 16'h6fff, 16'h6c00, 16'hf000, 16'h3c00};
    foreach (directed[i])
      send_block(directed[i], i > 1, (i == 0) ? 8'h00 : 8'hff);

    // long hold-off on the receiver so the block fills and stalls its input
    fork
      begin
        hold_off = 1'b1;
        repeat (150) @(posedge clk_i);
        hold_off = 1'b0;
      end
      repeat (5) send_block(pick_scale(), 1'b1, 8'h00);
    join

    // random blocks, with a stretch of no idling in the middle
    for (int n = 0; n < 52; n++) begin
      no_idle = (n >= 20 && n < 30);
      send_block(pick_scale(), 1'b1, 8'h00);
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    while (sb.pending_blocks.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) $display("q4_block_repack test passed");
    else $display("q4_block_repack test failed");
    $finish;
  end
endmodule

### filelist.f
src/q4br_pkg.sv
src/q4br_front.sv
src/q4br_back.sv
src/q4_block_repack.sv
dv/testbench.sv
